/* design/bpa_pkg.sv */
// bpa_pkg: shared types and constants of the buddy page allocator
// no dependencies; imported by bpa_step and buddy_page_allocator
package bpa_pkg;

    // page mark bits as kept in the metadata memory
    localparam logic [1:0] MARK_HEAD = 2'b01;
    localparam logic [1:0] MARK_FREE = 2'b10;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic {
        STEP_ADD = 1'b0,
        STEP_XOR = 1'b1
    } t_step_op;

    typedef struct packed {
        logic in_pool;   // computed page index lies inside the pool
        logic aligned;   // page is a multiple of the block size
        logic fits;      // page plus block size does not pass the pool end
    } t_step_flags;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SEARCH,
        S_A_SPLIT,
        S_A_SPLIT_CHK,
        S_A_FIN,
        S_F_CHK,
        S_F_MERGE,
        S_F_MCHK,
        S_F_MJOIN,
        S_UL_RD,
        S_UL_WR,
        S_PUSH1,
        S_PUSH2,
        S_DONE
    } t_state;

endpackage

/* design/bpa_ram.sv */
// bpa_ram: generic single write port, single read port ram, registered read
// no dependencies
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bpa_step.sv */
// bpa_step: shared block arithmetic unit (size shift, buddy add or xor, bound checks)
// depends on bpa_pkg
module bpa_step #(
    parameter int NUM_PAGES = 1024,
    parameter int MAX_ORDER = 10
) (
    input  logic [$clog2(NUM_PAGES)-1:0]   i_page,
    input  logic [$clog2(MAX_ORDER+2)-1:0] i_order,
    input  bpa_pkg::t_step_op              i_op,
    output logic [$clog2(NUM_PAGES)-1:0]   o_addr,
    output bpa_pkg::t_step_flags           o_flags
);
    import bpa_pkg::*;

    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = ((PW > MAX_ORDER) ? PW : MAX_ORDER) + 2;

    logic [CW-1:0] w_pow;
    logic [CW-1:0] w_page;
    logic [CW-1:0] w_sum;
    logic [CW-1:0] w_res;

    assign w_page = CW'(i_page);
    assign w_pow  = CW'(1) << i_order;
    assign w_sum  = w_page + w_pow;
    assign w_res  = (i_op == STEP_XOR) ? (w_page ^ w_pow) : w_sum;

    assign o_addr          = w_res[PW-1:0];
    assign o_flags.in_pool = w_res < CW'(NUM_PAGES);
    assign o_flags.aligned = (w_page & (w_pow - CW'(1))) == '0;
    assign o_flags.fits    = w_sum <= CW'(NUM_PAGES);

endmodule

/* design/buddy_page_allocator.sv */
// buddy_page_allocator: buddy allocator over a page pool, fifo free list per order
// depends on bpa_pkg, bpa_ram, bpa_step
//
//   channel | dir | tdata (low bit up)              | tuser
//   s       | in  | order[3:0], page[13:4], pad     | action (0 alloc, 1 free)
//   m       | out | page_res[9:0], pad              | status[1:0]
//
// a transaction is shortest when the order is out of range; the longest is an alloc
// that searches every order, then splits from the top order down to order 0. each step
// of the sequencer does one access to the link and metadata memories through the shared
// block unit.
// after reset every page of the metadata memory is swept; o_s_tready is low meanwhile.
// one request at a time; a finished result waits in the output register while the
// next request is taken, and the block stalls only if that register is still full.
module buddy_page_allocator #(
    parameter int MAX_ORDER = 10,
    parameter int NUM_PAGES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // order[3:0], page[13:4], zero pad
    input  logic        i_s_tuser,   // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // page_res[9:0], zero pad
    output logic [1:0]  o_m_tuser    // status
);
    import bpa_pkg::*;

    localparam int PW    = $clog2(NUM_PAGES);
    localparam int LW    = $clog2(NUM_PAGES + 1);
    localparam int OW    = $clog2(MAX_ORDER + 2);
    localparam int HW    = $clog2(MAX_ORDER + 1);
    localparam int MW    = OW + 2;
    localparam int NLIST = MAX_ORDER + 1;
    localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_state r_pret, n_pret;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [OW-1:0] r_ord, n_ord;
    logic [OW-1:0] r_o, n_o;
    logic [PW-1:0] r_p, n_p;
    logic [PW-1:0] r_b, n_b;
    logic [PW-1:0] r_up, n_up;
    logic [PW-1:0] r_pp, n_pp;
    logic [OW-1:0] r_po, n_po;
    logic [LW-1:0] r_otail, n_otail;
    logic [1:0]    r_cmarks, n_cmarks;
    t_status       r_stat, n_stat;
    logic [9:0]    r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic [9:0]    r_out_page, n_out_page;
    logic [LW-1:0] r_head [NLIST];
    logic [LW-1:0] n_head [NLIST];
    logic [LW-1:0] r_tail [NLIST];
    logic [LW-1:0] n_tail [NLIST];

    // memories
    logic          w_meta_we, w_prev_we, w_next_we;
    logic [PW-1:0] w_meta_waddr, w_meta_raddr;
    logic [PW-1:0] w_prev_waddr, w_next_waddr, w_link_raddr;
    logic [MW-1:0] w_meta_wdata, w_meta_rd;
    logic [LW-1:0] w_prev_wdata, w_next_wdata, w_prev_rd, w_next_rd;

    // shared block unit
    logic [PW-1:0] w_st_page, w_st_addr;
    logic [OW-1:0] w_st_order;
    t_step_op      w_st_op;
    t_step_flags   w_st_flags;

    logic          w_in_acc;
    logic          w_in_free;
    logic          w_ord_bad;
    logic          w_page_bad;
    logic [3:0]    w_in_order;
    logic [9:0]    w_in_page;
    logic [OW-1:0] w_rd_order;
    logic [1:0]    w_rd_marks;
    logic [LW-1:0] w_srch_head;
    logic          w_free_ok;
    logic          w_buddy_match;
    logic          w_out_load;

    bpa_ram #(.WIDTH(MW), .DEPTH(NUM_PAGES)) u_meta (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_raddr (w_meta_raddr),
        .o_rdata (w_meta_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_prev (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (w_prev_waddr),
        .i_wdata (w_prev_wdata),
        .i_raddr (w_link_raddr),
        .o_rdata (w_prev_rd)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_next (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_raddr (w_link_raddr),
        .o_rdata (w_next_rd)
    );

    bpa_step #(.NUM_PAGES(NUM_PAGES), .MAX_ORDER(MAX_ORDER)) u_step (
        .i_page  (w_st_page),
        .i_order (w_st_order),
        .i_op    (w_st_op),
        .o_addr  (w_st_addr),
        .o_flags (w_st_flags)
    );

    assign w_in_order = i_s_tdata[3:0];
    assign w_in_page  = i_s_tdata[13:4];
    assign w_in_free  = (t_action'(i_s_tuser) == ACT_FREE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_ord_bad  = 32'(w_in_order) > MAX_ORDER;
    assign w_page_bad = 32'(w_in_page) >= NUM_PAGES;
    assign w_rd_order = w_meta_rd[MW-1:2];
    assign w_rd_marks = w_meta_rd[1:0];
    assign w_srch_head = r_head[r_o[HW-1:0]];
    assign w_free_ok  = w_rd_marks[0] && !w_rd_marks[1]
                        && w_st_flags.aligned && w_st_flags.fits;
    assign w_buddy_match = (w_rd_order == r_o) && (w_rd_marks == (MARK_HEAD | MARK_FREE));
    assign w_out_load = !r_out_valid || i_m_tready;

    // shared unit operands
    always_comb begin
        w_st_page  = r_p;
        w_st_order = r_o;
        w_st_op    = STEP_XOR;
        unique case (r_state)
            S_A_SPLIT: begin
                w_st_order = r_o - OW'(1);
                w_st_op    = STEP_ADD;
            end
            S_F_CHK: begin
                w_st_op = STEP_ADD;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_cnt == PW'(NUM_PAGES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (w_ord_bad || (w_in_free && w_page_bad)) n_state = S_DONE;
                    else if (w_in_free) n_state = S_F_CHK;
                    else n_state = S_A_SEARCH;
                end
            end
            S_A_SEARCH: begin
                if (r_o > OW'(MAX_ORDER)) n_state = S_DONE;
                else if (w_srch_head != NIL) n_state = S_UL_RD;
            end
            S_A_SPLIT: begin
                if (r_o > r_ord) begin
                    if (w_st_flags.in_pool) n_state = S_A_SPLIT_CHK;
                end else begin
                    n_state = S_A_FIN;
                end
            end
            S_A_SPLIT_CHK: n_state = (w_rd_marks & MARK_FREE) != '0 ? S_UL_RD : S_PUSH1;
            S_A_FIN:       n_state = S_DONE;
            S_F_CHK:       n_state = w_free_ok ? S_F_MERGE : S_DONE;
            S_F_MERGE: begin
                if (r_o < OW'(MAX_ORDER) && w_st_flags.in_pool) n_state = S_F_MCHK;
                else n_state = S_PUSH1;
            end
            S_F_MCHK:  n_state = w_buddy_match ? S_UL_RD : S_PUSH1;
            S_F_MJOIN: n_state = S_F_MERGE;
            S_UL_RD:   n_state = S_UL_WR;
            S_UL_WR:   n_state = r_ret;
            S_PUSH1:   n_state = S_PUSH2;
            S_PUSH2:   n_state = r_pret;
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_ret     = r_ret;
        n_pret    = r_pret;
        n_cnt     = r_cnt;
        n_ord     = r_ord;
        n_o       = r_o;
        n_p       = r_p;
        n_b       = r_b;
        n_up      = r_up;
        n_pp      = r_pp;
        n_po      = r_po;
        n_otail   = r_otail;
        n_cmarks  = r_cmarks;
        n_stat    = r_stat;
        n_res     = r_res;
        n_head    = r_head;
        n_tail    = r_tail;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;

        w_meta_we    = 1'b0;
        w_meta_waddr = r_p;
        w_meta_wdata = '0;
        w_meta_raddr = r_up;
        w_prev_we    = 1'b0;
        w_prev_waddr = r_pp;
        w_prev_wdata = NIL;
        w_next_we    = 1'b0;
        w_next_waddr = r_pp;
        w_next_wdata = NIL;
        w_link_raddr = r_up;

        unique case (r_state)
            S_CLEAR: begin
                w_meta_we    = 1'b1;
                w_meta_waddr = r_cnt;
                w_meta_wdata = {OW'(0), MARK_HEAD};
                n_cnt        = r_cnt + PW'(1);
            end
            S_IDLE: begin
                w_meta_raddr = PW'(w_in_page);
                n_ord  = OW'(w_in_order);
                n_o    = OW'(w_in_order);
                n_p    = PW'(w_in_page);
                n_res  = '0;
                n_stat = ST_OK;
                n_pret = w_in_free ? S_DONE : S_A_SPLIT;
                if (w_ord_bad || (w_in_free && w_page_bad)) begin
                    n_stat = w_in_free ? ST_BADFREE : ST_NOMEM;
                end
            end
            S_A_SEARCH: begin
                if (r_o > OW'(MAX_ORDER)) begin
                    n_stat = ST_NOMEM;
                end else if (w_srch_head != NIL) begin
                    n_p   = w_srch_head[PW-1:0];
                    n_up  = w_srch_head[PW-1:0];
                    n_ret = S_A_SPLIT;
                end else begin
                    n_o = r_o + OW'(1);
                end
            end
            S_A_SPLIT: begin
                if (r_o > r_ord) begin
                    n_o          = r_o - OW'(1);
                    n_b          = w_st_addr;
                    w_meta_raddr = w_st_addr;
                end
            end
            S_A_SPLIT_CHK: begin
                // upper half goes on the list one order down
                n_pp  = r_b;
                n_po  = r_o;
                n_up  = r_b;
                n_ret = S_PUSH1;
            end
            S_A_FIN: begin
                w_meta_we    = 1'b1;
                w_meta_waddr = r_p;
                w_meta_wdata = {r_o, r_cmarks & ~MARK_FREE};
                n_res        = 10'(r_p);
            end
            S_F_CHK: begin
                if (w_free_ok) begin
                    w_meta_we    = 1'b1;
                    w_meta_waddr = r_p;
                    w_meta_wdata = '0;
                end else begin
                    n_stat = ST_BADFREE;
                end
            end
            S_F_MERGE: begin
                n_pp = r_p;
                n_po = r_o;
                n_b  = w_st_addr;
                w_meta_raddr = w_st_addr;
            end
            S_F_MCHK: begin
                n_up  = r_b;
                n_ret = S_F_MJOIN;
            end
            S_F_MJOIN: begin
                w_meta_we    = 1'b1;
                w_meta_waddr = r_b;
                w_meta_wdata = '0;
                if (r_b < r_p) n_p = r_b;
                n_o = r_o + OW'(1);
            end
            S_UL_RD: begin
                w_meta_raddr = r_up;
                w_link_raddr = r_up;
            end
            S_UL_WR: begin
                if (r_ret == S_A_SPLIT) n_cmarks = w_rd_marks;
                if (w_rd_order <= OW'(MAX_ORDER)) begin
                    if (w_prev_rd < NIL) begin
                        w_next_we    = 1'b1;
                        w_next_waddr = w_prev_rd[PW-1:0];
                        w_next_wdata = w_next_rd;
                    end else begin
                        n_head[w_rd_order[HW-1:0]] = w_next_rd;
                    end
                    if (w_next_rd < NIL) begin
                        w_prev_we    = 1'b1;
                        w_prev_waddr = w_next_rd[PW-1:0];
                        w_prev_wdata = w_prev_rd;
                    end else begin
                        n_tail[w_rd_order[HW-1:0]] = w_prev_rd;
                    end
                end
            end
            S_PUSH1: begin
                w_meta_we    = 1'b1;
                w_meta_waddr = r_pp;
                w_meta_wdata = {r_po, MARK_HEAD | MARK_FREE};
                w_prev_we    = 1'b1;
                w_prev_waddr = r_pp;
                w_prev_wdata = r_tail[r_po[HW-1:0]];
                w_next_we    = 1'b1;
                w_next_waddr = r_pp;
                w_next_wdata = NIL;
                n_otail      = r_tail[r_po[HW-1:0]];
                if (r_tail[r_po[HW-1:0]] == NIL) n_head[r_po[HW-1:0]] = LW'(r_pp);
                n_tail[r_po[HW-1:0]] = LW'(r_pp);
            end
            S_PUSH2: begin
                if (r_otail != NIL) begin
                    w_next_we    = 1'b1;
                    w_next_waddr = r_otail[PW-1:0];
                    w_next_wdata = LW'(r_pp);
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_stat;
                    n_out_page   = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NLIST; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret        <= n_ret;
        r_pret       <= n_pret;
        r_ord        <= n_ord;
        r_o          <= n_o;
        r_p          <= n_p;
        r_b          <= n_b;
        r_up         <= n_up;
        r_pp         <= n_pp;
        r_po         <= n_po;
        r_otail      <= n_otail;
        r_cmarks     <= n_cmarks;
        r_stat       <= n_stat;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_page};
    assign o_m_tuser  = r_out_status;

    // memory sweep after reset blocks requests
    a_clear_blocks: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_tready)
        else $error("request taken during metadata sweep");

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_tready)
        else $error("second request taken before the first finished");

    // split walk never goes below the requested order
    a_split_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_SPLIT) |-> (r_o >= r_ord))
        else $error("split walked below requested order");

    // failed results carry page zero (a good free also returns page zero; only failures are checked)
    a_fail_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && t_status'(o_m_tuser) != ST_OK) |-> (o_m_tdata == '0))
        else $error("failed request returned a page");

endmodule
